// File: rtl/tla_pkg.sv
// ============================================================================
// tla_pkg - shared types and constants for the toroidal life automaton
// Opcodes, register index, payload structs and the sequencer state type.
// ============================================================================
package tla_pkg;

  localparam int TLA_ROWS = 64;
  localparam int TLA_COLS = 64;

  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_TOGGLE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // word index of the running register (paddr[2])
  localparam logic CFG_IDX_RUNNING = 1'b0;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] row_index;
    logic [5:0] column_index;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic accepted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_CLEAR,
    ST_INIT,
    ST_STEP
  } state_t;

endpackage

// File: rtl/toroidal_life_automaton.sv
// ============================================================================
// toroidal_life_automaton - B3/S23 life on a wrapped ROWS x COLS grid
// Row memory, command sequencer, APB register and the cell ring.
// ============================================================================
// The grid lives in a row-wide memory; every command is taken when start is
// high and busy is low and gives exactly one result, held on out_item for a
// single cycle with out_valid high; the receiver cannot stall, so sample it
// then. Busy stays high on set, toggle and read while the row read registers
// at the transfer, then modify/write; on clear while the rows are zeroed, one
// row written per cycle; and on step while the single memory read port feeds
// one row per cycle into the ring of COLS cells. Refused clear and step
// commands, out-of-range commands and unknown opcodes never raise busy. The
// result appears in the first cycle with busy low after the transfer. After
// reset a clearing pass over all rows runs with busy high; register writes
// over the APB port are taken at any time, so change running only while no
// command is in flight.
module toroidal_life_automaton
  import tla_pkg::*;
#(
  parameter int ROWS = TLA_ROWS,
  parameter int COLS = TLA_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CNTW = $clog2(ROWS + 3);

  localparam logic [CNTW-1:0] CNT_LAST_ROW  = CNTW'(ROWS - 1);
  localparam logic [CNTW-1:0] CNT_LAST_READ = CNTW'(ROWS);
  localparam logic [CNTW-1:0] CNT_SAVE0     = CNTW'(2);
  localparam logic [CNTW-1:0] CNT_FIRST_WR  = CNTW'(3);
  localparam logic [CNTW-1:0] CNT_STEP_END  = CNTW'(ROWS + 2);

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            running_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [2:0]      op_r;
  logic [RW-1:0]   row_r;
  logic [CW-1:0]   col_r;
  logic            val_r;
  logic            latch_item;

  logic [COLS-1:0] grid_mem [ROWS];
  logic [COLS-1:0] rdata_r;
  logic [RW-1:0]   mem_raddr;
  logic            mem_we;
  logic [RW-1:0]   mem_waddr;
  logic [COLS-1:0] mem_wdata;

  logic [COLS-1:0] saved0_r;
  logic            save0;
  logic            shift_en;
  logic            use_saved;
  logic [COLS-1:0] bot_row;
  logic [COLS-1:0] next_row;

  logic            in_range;
  logic            cur_bit;
  logic            cfg_wr;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == CFG_IDX_RUNNING) ? {31'b0, running_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == CFG_IDX_RUNNING) begin
      running_r <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // row memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= grid_mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // cell ring
  // --------------------------------------------------------------------------
  assign bot_row = use_saved ? saved0_r : rdata_r;

  tla_cell_row #(
    .COLS (COLS)
  ) u_cell_row (
    .clk      (clk),
    .shift_en (shift_en),
    .bot_row  (bot_row),
    .next_row (next_row)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_range = (32'(in_item.row_index) < ROWS) && (32'(in_item.column_index) < COLS);
  assign cur_bit  = rdata_r[col_r];
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    latch_item    = 1'b0;
    mem_raddr     = RW'(in_item.row_index);
    mem_we        = 1'b0;
    mem_waddr     = row_r;
    mem_wdata     = rdata_r;
    save0         = 1'b0;
    shift_en      = 1'b0;
    use_saved     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.opcode)
            OP_SET, OP_TOGGLE, OP_READ: begin
              if (in_range) begin
                latch_item = 1'b1;
                state_nxt  = ST_RMW;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (!running_r) begin
                cnt_nxt   = '0;
                state_nxt = ST_CLEAR;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_STEP: begin
              if (running_r) begin
                cnt_nxt   = '0;
                state_nxt = ST_STEP;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_RMW: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        case (op_r)
          OP_SET: begin
            mem_we             = 1'b1;
            mem_wdata[col_r]   = val_r;
            out_item_nxt       = '{cell_out: val_r, accepted: 1'b1};
          end
          OP_TOGGLE: begin
            if (!running_r) begin
              mem_we           = 1'b1;
              mem_wdata[col_r] = ~cur_bit;
              out_item_nxt     = '{cell_out: ~cur_bit, accepted: 1'b1};
            end else begin
              out_item_nxt     = '{cell_out: cur_bit, accepted: 1'b0};
            end
          end
          default: begin
            out_item_nxt = '{cell_out: cur_bit, accepted: 1'b1};
          end
        endcase
      end

      ST_CLEAR, ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = RW'(cnt_r);
        mem_wdata = '0;
        if (cnt_r == CNT_LAST_ROW) begin
          state_nxt = ST_IDLE;
          if (state_r == ST_CLEAR) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{cell_out: 1'b0, accepted: 1'b1};
          end
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end

      ST_STEP: begin
        // read order: last row, then rows 0 .. ROWS-1; old row 0 comes from
        // the saved copy at the end since it is already rewritten by then
        if (cnt_r == '0) begin
          mem_raddr = RW'(ROWS - 1);
        end else if (cnt_r <= CNT_LAST_READ) begin
          mem_raddr = RW'(cnt_r - CNTW'(1));
        end else begin
          mem_raddr = '0;
        end
        shift_en  = (cnt_r != '0);
        save0     = (cnt_r == CNT_SAVE0);
        use_saved = (cnt_r == CNT_STEP_END);
        if (cnt_r >= CNT_FIRST_WR) begin
          mem_we    = 1'b1;
          mem_waddr = RW'(cnt_r - CNT_FIRST_WR);
          mem_wdata = next_row;
        end
        if (cnt_r == CNT_STEP_END) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{cell_out: 1'b0, accepted: 1'b1};
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (latch_item) begin
      op_r  <= in_item.opcode;
      row_r <= RW'(in_item.row_index);
      col_r <= CW'(in_item.column_index);
      val_r <= in_item.cell_in;
    end
    if (save0) begin
      saved0_r <= rdata_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/tla_cell.sv
// ============================================================================
// tla_cell - one column cell of the generation engine
// Holds the upper and middle row bits of its column, shows its three-bit
// column to both neighbors and computes the next state of the middle bit.
// ============================================================================
module tla_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic       bot_in,
  input  logic [2:0] west_col,
  input  logic [2:0] east_col,
  output logic [2:0] col_out,
  output logic       next_cell
);

  logic       top_r;
  logic       mid_r;
  logic [3:0] live_cnt;

  // advance the window one row: top <- mid <- incoming row bit
  always_ff @(posedge clk) begin
    if (shift_en) begin
      top_r <= mid_r;
      mid_r <= bot_in;
    end
  end

  assign col_out = {top_r, mid_r, bot_in};

  assign live_cnt = 4'(west_col[2]) + 4'(west_col[1]) + 4'(west_col[0])
                  + 4'(east_col[2]) + 4'(east_col[1]) + 4'(east_col[0])
                  + 4'(top_r) + 4'(bot_in);

  // B3/S23
  assign next_cell = (live_cnt == 4'd3) | (mid_r & (live_cnt == 4'd2));

endmodule

// File: rtl/tla_cell_row.sv
// ============================================================================
// tla_cell_row - ring of column cells
// Chains COLS cells with wrapped east/west links and returns the next
// generation of the middle row.
// ============================================================================
module tla_cell_row #(
  parameter int COLS = 64
) (
  input  logic            clk,
  input  logic            shift_en,
  input  logic [COLS-1:0] bot_row,
  output logic [COLS-1:0] next_row
);

  logic [2:0] col_bits [COLS];

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    tla_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .bot_in    (bot_row[c]),
      .west_col  (col_bits[(c + COLS - 1) % COLS]),
      .east_col  (col_bits[(c + 1) % COLS]),
      .col_out   (col_bits[c]),
      .next_cell (next_row[c])
    );
  end

endmodule

// File: bench/tla_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tla_result_checker - result checker for the toroidal life automaton
// Keeps its own copy of the grid and the running bit, predicts the result of
// every command at its input transfer and compares each output transfer,
// field by field, with the oldest prediction still waiting.
// ============================================================================
module tla_result_checker
  import tla_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  logic [TLA_COLS-1:0] grid_rows [TLA_ROWS];
  logic                running_mode;
  out_item_t           result_queue [$];
  int unsigned         mismatches = 0;

  assign fail_count = mismatches;

  function automatic int live_neighbours(input int r, input int c);
    int up, dn, lf, rt;
    up = (r + TLA_ROWS - 1) % TLA_ROWS;
    dn = (r + 1) % TLA_ROWS;
    lf = (c + TLA_COLS - 1) % TLA_COLS;
    rt = (c + 1) % TLA_COLS;
    return grid_rows[up][lf] + grid_rows[up][c] + grid_rows[up][rt]
         + grid_rows[r][lf] + grid_rows[r][rt]
         + grid_rows[dn][lf] + grid_rows[dn][c] + grid_rows[dn][rt];
  endfunction

  // every cell reads the old generation; commit all at once
  function automatic void advance_generation();
    logic [TLA_COLS-1:0] next_rows [TLA_ROWS];
    int n;
    for (int r = 0; r < TLA_ROWS; r++) begin
      for (int c = 0; c < TLA_COLS; c++) begin
        n = live_neighbours(r, c);
        next_rows[r][c] = grid_rows[r][c] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    grid_rows = next_rows;
  endfunction

  function automatic out_item_t predict_command(input in_item_t cmd);
    out_item_t res;
    logic      in_range;
    res = '0;
    in_range = (cmd.row_index < TLA_ROWS) && (cmd.column_index < TLA_COLS);
    case (cmd.opcode)
      OP_SET: begin
        if (in_range) begin
          grid_rows[cmd.row_index][cmd.column_index] = cmd.cell_in;
          res.cell_out = cmd.cell_in;
          res.accepted = 1'b1;
        end
      end
      OP_TOGGLE: begin
        if (in_range) begin
          if (!running_mode) begin
            grid_rows[cmd.row_index][cmd.column_index] =
              ~grid_rows[cmd.row_index][cmd.column_index];
            res.accepted = 1'b1;
          end
          res.cell_out = grid_rows[cmd.row_index][cmd.column_index];
        end
      end
      OP_CLEAR: begin
        if (!running_mode) begin
          foreach (grid_rows[i]) grid_rows[i] = '0;
          res.accepted = 1'b1;
        end
      end
      OP_STEP: begin
        if (running_mode) begin
          advance_generation();
          res.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) begin
          res.cell_out = grid_rows[cmd.row_index][cmd.column_index];
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      foreach (grid_rows[i]) grid_rows[i] = '0;
      running_mode = 1'b0;
      result_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_RUNNING)
        running_mode = pwdata[0];
      if (out_valid) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual %b/%b",
                   $time, out_item.cell_out, out_item.accepted);
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          if (out_item.cell_out !== want.cell_out) begin
            $display("%0t: cell_out mismatch: expected %b, actual %b",
                     $time, want.cell_out, out_item.cell_out);
            mismatches++;
          end
          if (out_item.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %b, actual %b",
                     $time, want.accepted, out_item.accepted);
            mismatches++;
          end
        end
      end
      // an older result may leave in the same cycle; the queue keeps order
      if (start && !busy)
        result_queue.push_back(predict_command(in_item));
    end
    outstanding <= result_queue.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top - testbench for the toroidal life automaton
// Drives directed and random command sequences (edits while stopped, then
// generations and reads while running) over several idle patterns, switches
// the running register between phases, and reports the checker's verdict.
// ============================================================================
module tb_top
  import tla_pkg::*;
();

  localparam int          ITEM_TARGET   = 1450;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = TLA_ROWS + 20;

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned quiet_cycles  = 0;
  int unsigned idle_pct      = 0;
  int unsigned commands_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  toroidal_life_automaton i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tla_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [5:0] near(input logic [5:0] base, input int unsigned span);
    logic [5:0] offset;
    offset = 6'($urandom_range(span - 1));
    return base + offset;
  endfunction

  // present one command and hold it until the transfer
  task automatic send_command(input logic [2:0] op, input logic [5:0] r,
                              input logic [5:0] c, input logic v);
    in_item_t cmd;
    cmd.opcode       = op;
    cmd.row_index    = r;
    cmd.column_index = c;
    cmd.cell_in      = v;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
    if (op <= OP_READ)
      commands_sent++;
  endtask

  task automatic send_noise();
    send_command(3'($urandom_range(7)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                 1'($urandom_range(1)));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_running(input logic value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_IDX_RUNNING, 2'b00};
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned episode, edits, gens, peeks, pick, span;
    logic [5:0]  r0, c0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edits while stopped, corners, refusals, unknown codes
    send_command(OP_READ,   6'd0,  6'd0,  1'b0);
    send_command(OP_SET,    6'd0,  6'd0,  1'b1);
    send_command(OP_SET,    6'd63, 6'd63, 1'b1);
    send_command(OP_TOGGLE, 6'd0,  6'd63, 1'b0);
    send_command(OP_TOGGLE, 6'd0,  6'd63, 1'b1);
    send_command(OP_SET,    6'd63, 6'd0,  1'b1);
    send_command(OP_READ,   6'd63, 6'd63, 1'b0);
    send_command(OP_CLEAR,  6'd17, 6'd42, 1'b1);
    send_command(OP_READ,   6'd0,  6'd0,  1'b0);
    send_command(OP_STEP,   6'd0,  6'd0,  1'b0);
    send_command(3'd5,      6'd63, 6'd63, 1'b1);
    send_command(3'd6,      6'd63, 6'd63, 1'b1);
    send_command(3'd7,      6'd63, 6'd63, 1'b1);
    // blinker straddling the column wrap
    send_command(OP_SET,    6'd0,  6'd62, 1'b1);
    send_command(OP_SET,    6'd0,  6'd63, 1'b1);
    send_command(OP_SET,    6'd0,  6'd0,  1'b1);
    write_running(1'b1);
    send_command(OP_TOGGLE, 6'd1,  6'd63, 1'b1);
    send_command(OP_CLEAR,  6'd0,  6'd0,  1'b0);
    send_command(OP_STEP,   6'd0,  6'd0,  1'b0);
    send_command(OP_READ,   6'd63, 6'd63, 1'b0);
    send_command(OP_READ,   6'd1,  6'd63, 1'b0);
    send_command(OP_SET,    6'd5,  6'd5,  1'b1);
    send_command(OP_STEP,   6'd63, 6'd63, 1'b1);
    send_command(OP_READ,   6'd0,  6'd62, 1'b0);
    send_command(OP_READ,   6'd5,  6'd5,  1'b0);

    episode = 0;
    while (commands_sent < ITEM_TARGET) begin
      // receiver stalls cannot happen here, so its phase runs without idling
      case ((episode / 3) % 4)
        1:       idle_pct = 86;
        3:       idle_pct = 36;
        default: idle_pct = 0;
      endcase

      write_running(1'b0);
      if ($urandom_range(1))
        send_command(OP_CLEAR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     1'($urandom_range(1)));
      r0    = 6'($urandom_range(63));
      c0    = 6'($urandom_range(63));
      span  = ($urandom_range(7) == 0) ? 64 : $urandom_range(3, 10);
      edits = $urandom_range(8, 40);
      for (int i = 0; i < edits; i++) begin
        pick = $urandom_range(99);
        if (pick < 10)
          send_noise();
        else if (pick < 30)
          send_command(OP_TOGGLE, near(r0, span), near(c0, span), 1'($urandom_range(1)));
        else
          send_command(OP_SET, near(r0, span), near(c0, span), $urandom_range(99) < 65);
        if ($urandom_range(199) == 0)
          drain_results();
      end

      write_running(1'b1);
      gens = $urandom_range(1, 6);
      for (int g = 0; g < gens; g++) begin
        send_command(OP_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     1'($urandom_range(1)));
        peeks = $urandom_range(2, 8);
        for (int p = 0; p < peeks; p++) begin
          pick = $urandom_range(99);
          if (pick < 12)
            send_noise();
          else if (pick < 20)
            send_command(OP_SET, near(r0, span), near(c0, span), 1'($urandom_range(1)));
          else
            send_command(OP_READ, near(r0 - 6'd2, span + 4), near(c0 - 6'd2, span + 4),
                         1'($urandom_range(1)));
        end
      end
      episode++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
